@@ hdl/cist_pkg.sv @@
package cist_pkg;

  localparam int unsigned ID_W       = 29;
  localparam int unsigned KEY_W      = 30;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DLC_W      = 4;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned SLOT_W     = 7;
  localparam int unsigned USED_OUT_W = 8;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned NUM_BYTES  = 8;

  localparam logic [MODE_W-1:0] MODE_FRAME = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ID = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_UPDATED,
    ST_INSERTED,
    ST_FULL,
    ST_FILTERED,
    ST_READ_OK,
    ST_READ_EMPTY,
    ST_CLEARED
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] last_seen;
    logic [TIME_W-1:0] interval;
    logic [DLC_W-1:0]  dlc;
    logic [DATA_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic slot_rd;
    logic hit_wr;
    logic miss_wr;
    logic take_rd;
    logic no_entry;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              filtered;
    logic              read_ok;
    logic              scan_more;
    logic              cmp_valid;
    logic              match;
  } stat_t;

  function automatic logic [DATA_W-1:0] byte_mask(input logic [DLC_W-1:0] dlc);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < NUM_BYTES; b++) begin
      if (dlc > DLC_W'(b)) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

@@ hdl/cist_ctrl.sv @@
module cist_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  cist_pkg::stat_t stat_i,
  output cist_pkg::ctrl_t ctrl_o
);
  import cist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_READ,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    ctrl_o      = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.mode == MODE_CLEAR) begin
          ctrl_o.no_entry = 1'b1;
          state_d         = S_EMIT;
        end else if (stat_i.mode == MODE_FRAME) begin
          if (stat_i.filtered) begin
            ctrl_o.no_entry = 1'b1;
            state_d         = S_EMIT;
          end else begin
            state_d = S_SCAN;
          end
        end else if (stat_i.read_ok) begin
          ctrl_o.slot_rd = 1'b1;
          state_d        = S_READ;
        end else begin
          ctrl_o.no_entry = 1'b1;
          state_d         = S_EMIT;
        end
      end
      S_SCAN: begin
        if (stat_i.cmp_valid && stat_i.match) begin
          ctrl_o.hit_wr = 1'b1;
          state_d       = S_EMIT;
        end else if (stat_i.scan_more) begin
          ctrl_o.scan_rd = 1'b1;
        end else if (!stat_i.cmp_valid) begin
          ctrl_o.miss_wr = 1'b1;
          state_d        = S_EMIT;
        end
      end
      S_READ: begin
        ctrl_o.take_rd = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/cist_dp.sv @@
module cist_dp #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cist_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cist_pkg::ID_W-1:0]            cfg_wdata_i,
  input  logic [cist_pkg::MODE_W-1:0]          mode_i,
  input  logic [cist_pkg::ID_W-1:0]            frame_id_i,
  input  logic                                 is_extended_i,
  input  logic                                 is_remote_i,
  input  logic [cist_pkg::DLC_W-1:0]           frame_dlc_i,
  input  logic [cist_pkg::DATA_W-1:0]          frame_payload_i,
  input  logic [cist_pkg::TIME_W-1:0]          time_ms_i,
  input  logic [cist_pkg::SLOT_W-1:0]          read_slot_i,
  input  cist_pkg::ctrl_t                      ctrl_i,
  output cist_pkg::stat_t                      stat_o,
  output logic [cist_pkg::STAT_W-1:0]          status_o,
  output logic [cist_pkg::SLOT_W-1:0]          slot_o,
  output logic [cist_pkg::ID_W-1:0]            entry_id_o,
  output logic                                 entry_extended_o,
  output logic [cist_pkg::CNT_W-1:0]           entry_count_o,
  output logic [cist_pkg::TIME_W-1:0]          entry_interval_ms_o,
  output logic [cist_pkg::TIME_W-1:0]          entry_last_seen_ms_o,
  output logic [cist_pkg::DLC_W-1:0]           entry_dlc_o,
  output logic [cist_pkg::DATA_W-1:0]          entry_payload_o,
  output logic [cist_pkg::USED_OUT_W-1:0]      entries_used_o,
  output logic [cist_pkg::CNT_W-1:0]           total_frames_o
);
  import cist_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned UW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW    = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic              filt_en_q;
  logic [ID_W-1:0]   filt_id_q;
  logic [MODE_W-1:0] mode_q;
  logic [ID_W-1:0]   id_q;
  logic              ext_q;
  logic              rem_q;
  logic [DLC_W-1:0]  dlc_q;
  logic [DATA_W-1:0] data_q;
  logic [TIME_W-1:0] time_q;
  logic [SLOT_W-1:0] rslot_q;
  logic [UW-1:0]     used_q;
  logic [CNT_W-1:0]  total_q;
  logic [UW-1:0]     scan_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              cmp_vld_q;

  entry_t            mem_q [TABLE_DEPTH];
  entry_t            rd_q;

  status_e           res_status_q;
  logic [SLOT_W-1:0] res_slot_q;
  entry_t            res_entry_q;

  status_e           out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  entry_t            out_entry_q;
  logic [USED_OUT_W-1:0] out_used_q;
  logic [CNT_W-1:0]  out_total_q;

  logic [KEY_W-1:0]  key;
  logic [CW-1:0]     rslot_w;
  logic [CW-1:0]     used_w;
  logic [DATA_W-1:0] mask;
  logic              can_ins;
  entry_t            upd;
  entry_t            ins;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  always_comb begin
    key     = {ext_q, id_q};
    rslot_w = CW'(rslot_q);
    used_w  = CW'(used_q);
    mask    = byte_mask(dlc_q);
    can_ins = used_w < DEPTH_C;

    upd.key       = rd_q.key;
    upd.count     = rd_q.count + 1'b1;
    upd.interval  = time_q - rd_q.last_seen;
    upd.last_seen = time_q;
    upd.dlc       = dlc_q;
    upd.payload   = rem_q ? rd_q.payload : ((rd_q.payload & ~mask) | (data_q & mask));

    ins.key       = key;
    ins.count     = CNT_W'(1);
    ins.interval  = '0;
    ins.last_seen = time_q;
    ins.dlc       = dlc_q;
    ins.payload   = rem_q ? '0 : (data_q & mask);

    rd_en   = ctrl_i.scan_rd || ctrl_i.slot_rd;
    rd_addr = ctrl_i.slot_rd ? rslot_w[IDX_W-1:0] : scan_q[IDX_W-1:0];
    wr_en   = ctrl_i.hit_wr || (ctrl_i.miss_wr && can_ins);
    wr_addr = ctrl_i.hit_wr ? cmp_idx_q : used_w[IDX_W-1:0];
    wr_data = ctrl_i.hit_wr ? upd : ins;

    stat_o.mode      = mode_q;
    stat_o.filtered  = filt_en_q && (id_q != filt_id_q);
    stat_o.read_ok   = rslot_w < used_w;
    stat_o.scan_more = scan_q < used_q;
    stat_o.cmp_valid = cmp_vld_q;
    stat_o.match     = (rd_q.key == key);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_en_q <= 1'b0;
      filt_id_q <= '0;
      used_q    <= '0;
      total_q   <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FILTER_EN) begin
          filt_en_q <= cfg_wdata_i[0];
        end else begin
          filt_id_q <= cfg_wdata_i;
        end
      end
      if (ctrl_i.load) begin
        scan_q <= '0;
        if (mode_i == MODE_CLEAR) begin
          used_q  <= '0;
          total_q <= '0;
        end else if (mode_i == MODE_FRAME) begin
          total_q <= total_q + 1'b1;
        end
      end
      if (ctrl_i.scan_rd) begin
        scan_q <= scan_q + 1'b1;
      end
      cmp_vld_q <= ctrl_i.scan_rd;
      if (ctrl_i.miss_wr && can_ins) begin
        used_q <= used_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mode_q  <= mode_i;
      id_q    <= frame_id_i;
      ext_q   <= is_extended_i;
      rem_q   <= is_remote_i;
      dlc_q   <= frame_dlc_i;
      data_q  <= frame_payload_i;
      time_q  <= time_ms_i;
      rslot_q <= read_slot_i;
    end
    if (ctrl_i.scan_rd) begin
      cmp_idx_q <= scan_q[IDX_W-1:0];
    end
    if (ctrl_i.hit_wr) begin
      res_status_q <= ST_UPDATED;
      res_slot_q   <= SLOT_W'(cmp_idx_q);
      res_entry_q  <= upd;
    end
    if (ctrl_i.miss_wr) begin
      if (can_ins) begin
        res_status_q <= ST_INSERTED;
        res_slot_q   <= SLOT_W'(used_q);
        res_entry_q  <= ins;
      end else begin
        res_status_q <= ST_FULL;
        res_slot_q   <= '0;
        res_entry_q  <= '0;
      end
    end
    if (ctrl_i.take_rd) begin
      res_status_q <= ST_READ_OK;
      res_slot_q   <= rslot_q;
      res_entry_q  <= rd_q;
    end
    if (ctrl_i.no_entry) begin
      res_entry_q <= '0;
      if (mode_q == MODE_CLEAR) begin
        res_status_q <= ST_CLEARED;
        res_slot_q   <= '0;
      end else if (mode_q == MODE_FRAME) begin
        res_status_q <= ST_FILTERED;
        res_slot_q   <= '0;
      end else begin
        res_status_q <= ST_READ_EMPTY;
        res_slot_q   <= rslot_q;
      end
    end
    if (ctrl_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_entry_q  <= res_entry_q;
      out_used_q   <= USED_OUT_W'(used_q);
      out_total_q  <= total_q;
    end
  end

  assign status_o             = out_status_q;
  assign slot_o               = out_slot_q;
  assign entry_id_o           = out_entry_q.key[ID_W-1:0];
  assign entry_extended_o     = out_entry_q.key[KEY_W-1];
  assign entry_count_o        = out_entry_q.count;
  assign entry_interval_ms_o  = out_entry_q.interval;
  assign entry_last_seen_ms_o = out_entry_q.last_seen;
  assign entry_dlc_o          = out_entry_q.dlc;
  assign entry_payload_o      = out_entry_q.payload;
  assign entries_used_o       = out_used_q;
  assign total_frames_o       = out_total_q;

endmodule

@@ hdl/can_id_statistics_table.sv @@
// a frame is decided, then looked up by a linear search through the single-port entry
// memory, one entry per cycle, that ends at the first match (hit) or after the entries
// in use (miss, at once on an empty table); its result is emitted once the output is free
// a read goes through the decide, read and emit states; an empty read, a clear or a
// filtered frame goes from decide to emit; one item in work at a time, accepted in idle
// reset clears the counters, the filter and the handshake state; entry memory is not cleared
module can_id_statistics_table #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cist_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cist_pkg::ID_W-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [cist_pkg::MODE_W-1:0]          mode_i,
  input  logic [cist_pkg::ID_W-1:0]            frame_id_i,
  input  logic                                 is_extended_i,
  input  logic                                 is_remote_i,
  input  logic [cist_pkg::DLC_W-1:0]           frame_dlc_i,
  input  logic [cist_pkg::DATA_W-1:0]          frame_payload_i,
  input  logic [cist_pkg::TIME_W-1:0]          time_ms_i,
  input  logic [cist_pkg::SLOT_W-1:0]          read_slot_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [cist_pkg::STAT_W-1:0]          status_o,
  output logic [cist_pkg::SLOT_W-1:0]          slot_o,
  output logic [cist_pkg::ID_W-1:0]            entry_id_o,
  output logic                                 entry_extended_o,
  output logic [cist_pkg::CNT_W-1:0]           entry_count_o,
  output logic [cist_pkg::TIME_W-1:0]          entry_interval_ms_o,
  output logic [cist_pkg::TIME_W-1:0]          entry_last_seen_ms_o,
  output logic [cist_pkg::DLC_W-1:0]           entry_dlc_o,
  output logic [cist_pkg::DATA_W-1:0]          entry_payload_o,
  output logic [cist_pkg::USED_OUT_W-1:0]      entries_used_o,
  output logic [cist_pkg::CNT_W-1:0]           total_frames_o
);
  import cist_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  cist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  cist_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .mode_i               (mode_i),
    .frame_id_i           (frame_id_i),
    .is_extended_i        (is_extended_i),
    .is_remote_i          (is_remote_i),
    .frame_dlc_i          (frame_dlc_i),
    .frame_payload_i      (frame_payload_i),
    .time_ms_i            (time_ms_i),
    .read_slot_i          (read_slot_i),
    .ctrl_i               (ctrl),
    .stat_o               (stat),
    .status_o             (status_o),
    .slot_o               (slot_o),
    .entry_id_o           (entry_id_o),
    .entry_extended_o     (entry_extended_o),
    .entry_count_o        (entry_count_o),
    .entry_interval_ms_o  (entry_interval_ms_o),
    .entry_last_seen_ms_o (entry_last_seen_ms_o),
    .entry_dlc_o          (entry_dlc_o),
    .entry_payload_o      (entry_payload_o),
    .entries_used_o       (entries_used_o),
    .total_frames_o       (total_frames_o)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import cist_pkg::*;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned POOL_N = 20;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic              ext;
    logic              remote;
    logic [DLC_W-1:0]  dlc;
    logic [DATA_W-1:0] data;
    logic [TIME_W-1:0] ms;
    logic [SLOT_W-1:0] rslot;
  } can_item_t;

  typedef struct packed {
    status_e               status;
    logic [SLOT_W-1:0]     slot;
    logic [ID_W-1:0]       id;
    logic                  ext;
    logic [CNT_W-1:0]      count;
    logic [TIME_W-1:0]     interval;
    logic [TIME_W-1:0]     last_seen;
    logic [DLC_W-1:0]      dlc;
    logic [DATA_W-1:0]     payload;
    logic [USED_OUT_W-1:0] used;
    logic [CNT_W-1:0]      total;
  } table_reply_t;

  class id_table_tracker;
    bit [KEY_W-1:0]  keys [DEPTH];
    bit [CNT_W-1:0]  counts [DEPTH];
    bit [TIME_W-1:0] last_seen [DEPTH];
    bit [TIME_W-1:0] intervals [DEPTH];
    bit [DLC_W-1:0]  dlcs [DEPTH];
    bit [DATA_W-1:0] payloads [DEPTH];
    int unsigned     used;
    bit [CNT_W-1:0]  total;
    bit              filter_on;
    bit [ID_W-1:0]   filter_value;
    table_reply_t    replies [$];
    int unsigned     errors;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] value);
      if (idx == CFG_FILTER_EN) begin
        filter_on = value[0];
      end else begin
        filter_value = value;
      end
    endfunction

    function table_reply_t entry_reply(status_e st, bit [SLOT_W-1:0] slot, int idx);
      table_reply_t r;
      r = '0;
      r.status = st;
      r.slot = slot;
      if (idx >= 0) begin
        r.id = keys[idx][ID_W-1:0];
        r.ext = keys[idx][ID_W];
        r.count = counts[idx];
        r.interval = intervals[idx];
        r.last_seen = last_seen[idx];
        r.dlc = dlcs[idx];
        r.payload = payloads[idx];
      end
      r.used = USED_OUT_W'(used);
      r.total = total;
      return r;
    endfunction

    // works out the reply to one accepted transfer
    function void note_item(can_item_t it);
      bit [KEY_W-1:0]  key;
      bit [DATA_W-1:0] lanes;
      int              hit;
      key = {it.ext, it.id};
      lanes = (it.dlc >= 8) ? '1 : (64'd1 << (8 * it.dlc)) - 64'd1;
      if (it.mode == MODE_CLEAR) begin
        used = 0;
        total = '0;
        replies.push_back(entry_reply(ST_CLEARED, '0, -1));
        return;
      end
      if (it.mode != MODE_FRAME) begin
        if (it.rslot < used) begin
          replies.push_back(entry_reply(ST_READ_OK, it.rslot, int'(it.rslot)));
        end else begin
          replies.push_back(entry_reply(ST_READ_EMPTY, it.rslot, -1));
        end
        return;
      end
      total = total + 1;
      if (filter_on && it.id != filter_value) begin
        replies.push_back(entry_reply(ST_FILTERED, '0, -1));
        return;
      end
      hit = -1;
      for (int i = 0; i < used; i++) begin
        if (keys[i] == key) begin
          hit = i;
          break;
        end
      end
      if (hit >= 0) begin
        counts[hit] = counts[hit] + 1;
        intervals[hit] = it.ms - last_seen[hit];
        last_seen[hit] = it.ms;
        dlcs[hit] = it.dlc;
        if (!it.remote) begin
          payloads[hit] = (payloads[hit] & ~lanes) | (it.data & lanes);
        end
        replies.push_back(entry_reply(ST_UPDATED, SLOT_W'(hit), hit));
      end else if (used < DEPTH) begin
        keys[used] = key;
        counts[used] = 1;
        last_seen[used] = it.ms;
        intervals[used] = '0;
        dlcs[used] = it.dlc;
        payloads[used] = it.remote ? '0 : (it.data & lanes);
        used++;
        replies.push_back(entry_reply(ST_INSERTED, SLOT_W'(used - 1), int'(used - 1)));
      end else begin
        replies.push_back(entry_reply(ST_FULL, '0, -1));
      end
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    task compare_field(string name, logic [63:0] seen, logic [63:0] want);
      if (seen !== want) begin
        report($sformatf("%s got %0h want %0h", name, seen, want));
      end
    endtask

    task check_result(table_reply_t seen);
      table_reply_t want;
      if (replies.size() == 0) begin
        report("result transfer with nothing expected");
        return;
      end
      want = replies.pop_front();
      compare_field("status", seen.status, want.status);
      compare_field("slot", seen.slot, want.slot);
      compare_field("entry_id", seen.id, want.id);
      compare_field("entry_extended", seen.ext, want.ext);
      compare_field("entry_count", seen.count, want.count);
      compare_field("entry_interval_ms", seen.interval, want.interval);
      compare_field("entry_last_seen_ms", seen.last_seen, want.last_seen);
      compare_field("entry_dlc", seen.dlc, want.dlc);
      compare_field("entry_payload", seen.payload, want.payload);
      compare_field("entries_used", seen.used, want.used);
      compare_field("total_frames", seen.total, want.total);
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = CFG_FILTER_EN;
  logic [ID_W-1:0]         cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [MODE_W-1:0]       mode_i = MODE_FRAME;
  logic [ID_W-1:0]         frame_id_i = '0;
  logic                    is_extended_i = 1'b0;
  logic                    is_remote_i = 1'b0;
  logic [DLC_W-1:0]        frame_dlc_i = '0;
  logic [DATA_W-1:0]       frame_payload_i = '0;
  logic [TIME_W-1:0]       time_ms_i = '0;
  logic [SLOT_W-1:0]       read_slot_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [STAT_W-1:0]       status_o;
  logic [SLOT_W-1:0]       slot_o;
  logic [ID_W-1:0]         entry_id_o;
  logic                    entry_extended_o;
  logic [CNT_W-1:0]        entry_count_o;
  logic [TIME_W-1:0]       entry_interval_ms_o;
  logic [TIME_W-1:0]       entry_last_seen_ms_o;
  logic [DLC_W-1:0]        entry_dlc_o;
  logic [DATA_W-1:0]       entry_payload_o;
  logic [USED_OUT_W-1:0]   entries_used_o;
  logic [CNT_W-1:0]        total_frames_o;

  id_table_tracker tracker = new;
  table_reply_t    observed;
  bit              idle_on = 1'b1;
  int unsigned     quiet_cycles = 0;
  bit [TIME_W-1:0] clock_ms = '0;
  bit [ID_W-1:0]   pool_id [POOL_N];
  bit              pool_ext [POOL_N];

  can_id_statistics_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .mode_i              (mode_i),
    .frame_id_i          (frame_id_i),
    .is_extended_i       (is_extended_i),
    .is_remote_i         (is_remote_i),
    .frame_dlc_i         (frame_dlc_i),
    .frame_payload_i     (frame_payload_i),
    .time_ms_i           (time_ms_i),
    .read_slot_i         (read_slot_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .slot_o              (slot_o),
    .entry_id_o          (entry_id_o),
    .entry_extended_o    (entry_extended_o),
    .entry_count_o       (entry_count_o),
    .entry_interval_ms_o (entry_interval_ms_o),
    .entry_last_seen_ms_o(entry_last_seen_ms_o),
    .entry_dlc_o         (entry_dlc_o),
    .entry_payload_o     (entry_payload_o),
    .entries_used_o      (entries_used_o),
    .total_frames_o      (total_frames_o)
  );

  assign observed = {status_o, slot_o, entry_id_o, entry_extended_o, entry_count_o,
                     entry_interval_ms_o, entry_last_seen_ms_o, entry_dlc_o,
                     entry_payload_o, entries_used_o, total_frames_o};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls, checking and the watchdog
  always @(posedge clk_i) begin
    out_ready_i <= !(idle_on && $urandom_range(0, 99) < 15);
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        tracker.check_result(observed);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("testbench: errors");
          $finish;
        end
      end
    end
  end

  function automatic can_item_t noise_item();
    can_item_t it;
    it.mode = MODE_W'($urandom_range(0, 3));
    it.id = ID_W'($urandom);
    it.ext = 1'($urandom);
    it.remote = 1'($urandom);
    it.dlc = DLC_W'($urandom);
    it.data = {$urandom, $urandom};
    it.ms = $urandom;
    it.rslot = SLOT_W'($urandom);
    return it;
  endfunction

  task automatic send_item(input can_item_t it);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 99) < 15) begin
      gap = 1;
      while ($urandom_range(0, 99) < 40) gap++;
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= it.mode;
    frame_id_i <= it.id;
    is_extended_i <= it.ext;
    is_remote_i <= it.remote;
    frame_dlc_i <= it.dlc;
    frame_payload_i <= it.data;
    time_ms_i <= it.ms;
    read_slot_i <= it.rslot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_item(it);
  endtask

  task automatic send_frame(input logic [ID_W-1:0] id, input logic ext, input logic remote,
                            input logic [DLC_W-1:0] dlc, input logic [DATA_W-1:0] data,
                            input logic [TIME_W-1:0] ms);
    can_item_t it;
    it = noise_item();
    it.mode = MODE_FRAME;
    it.id = id;
    it.ext = ext;
    it.remote = remote;
    it.dlc = dlc;
    it.data = data;
    it.ms = ms;
    send_item(it);
  endtask

  task automatic send_ctl(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot);
    can_item_t it;
    it = noise_item();
    it.mode = mode;
    it.rslot = slot;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_filter(input logic enable, input logic [ID_W-1:0] id);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_FILTER_EN;
    cfg_wdata_i <= ID_W'(enable);
    @(posedge clk_i);
    cfg_idx_i <= CFG_FILTER_ID;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_register(CFG_FILTER_EN, ID_W'(enable));
    tracker.set_register(CFG_FILTER_ID, id);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned pick;
    int unsigned k;
    int unsigned hi;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) begin
        clock_ms = $urandom;
      end else begin
        clock_ms = clock_ms + $urandom_range(0, 300);
      end
      hi = (tracker.used + 1 > DEPTH - 1) ? DEPTH - 1 : tracker.used + 1;
      if (pick < 3) begin
        send_ctl(MODE_CLEAR, SLOT_W'($urandom));
      end else if (pick < 18) begin
        send_ctl((pick < 15) ? MODE_READ : MODE_SPARE,
                 ($urandom_range(0, 99) < 75) ? SLOT_W'($urandom_range(0, hi))
                                              : SLOT_W'($urandom));
      end else if (pick < 28) begin
        send_frame(ID_W'($urandom), 1'($urandom), $urandom_range(0, 9) == 0,
                   DLC_W'($urandom), {$urandom, $urandom}, clock_ms);
      end else begin
        k = $urandom_range(0, POOL_N - 1);
        send_frame(pool_id[k], pool_ext[k], $urandom_range(0, 9) == 0,
                   DLC_W'($urandom), {$urandom, $urandom}, clock_ms);
      end
    end
  endtask

  initial begin
    logic [ID_W-1:0] last_id;
    logic            last_ext;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty reads, inserts, updates, wraps, remote frames, clear, then the filter
    send_ctl(MODE_READ, 7'd0);
    send_ctl(MODE_SPARE, 7'd127);
    send_frame(29'h7FF, 1'b0, 1'b0, 4'd8, '1, 32'd0);
    send_frame(29'h7FF, 1'b1, 1'b0, 4'd8, 64'h0123_4567_89AB_CDEF, 32'd10);
    send_frame(29'h0, 1'b0, 1'b0, 4'd0, '1, 32'd20);
    send_frame(29'h1FFF_FFFF, 1'b1, 1'b0, 4'd15, '1, 32'd30);
    send_frame(29'h7FF, 1'b0, 1'b0, 4'd3, '0, 32'hFFFF_FFF0);
    send_frame(29'h7FF, 1'b0, 1'b1, 4'd8, '0, 32'd5);
    send_frame(29'h155, 1'b0, 1'b1, 4'd8, '1, 32'd40);
    send_frame(29'h0, 1'b0, 1'b0, 4'd12, 64'hA5A5_5A5A_C3C3_3C3C, 32'd50);
    send_frame(29'h1FFF_FFFF, 1'b0, 1'b0, 4'd1, {$urandom, $urandom}, 32'hFFFF_FFFF);
    send_ctl(MODE_READ, 7'd0);
    send_ctl(MODE_SPARE, 7'd3);
    send_ctl(MODE_READ, 7'd5);
    send_ctl(MODE_READ, 7'd6);
    send_ctl(MODE_READ, 7'd127);
    send_ctl(MODE_CLEAR, 7'd0);
    send_ctl(MODE_READ, 7'd0);
    send_frame(29'h2AA, 1'b1, 1'b0, 4'd5, {$urandom, $urandom}, 32'd60);
    send_ctl(MODE_READ, 7'd0);
    wait_drained();
    program_filter(1'b1, 29'h7FF);
    send_frame(29'h7FF, 1'b1, 1'b0, 4'd2, {$urandom, $urandom}, 32'd70);
    send_frame(29'h123, 1'b0, 1'b0, 4'd8, {$urandom, $urandom}, 32'd80);
    send_frame(29'h7FF, 1'b0, 1'b0, 4'd7, {$urandom, $urandom}, 32'd90);
    send_ctl(MODE_READ, 7'd1);
    wait_drained();
    program_filter(1'b0, '0);

    // fill the table to the last entry, then overflow it
    idle_on = 1'b0;
    send_ctl(MODE_CLEAR, 7'd0);
    last_id = '0;
    last_ext = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      last_id = {1'b0, 21'($urandom), 7'(i)};
      last_ext = 1'($urandom);
      clock_ms = clock_ms + $urandom_range(1, 50);
      send_frame(last_id, last_ext, 1'b0, DLC_W'($urandom), {$urandom, $urandom}, clock_ms);
    end
    repeat (4) begin
      send_frame({1'b1, 28'($urandom)}, 1'($urandom), 1'b0, DLC_W'($urandom),
                 {$urandom, $urandom}, clock_ms);
    end
    send_frame(last_id, last_ext, 1'b0, 4'd4, {$urandom, $urandom}, clock_ms + 32'd7);
    send_ctl(MODE_READ, 7'd127);
    send_ctl(MODE_READ, 7'd0);
    idle_on = 1'b1;

    for (int i = 0; i < POOL_N; i++) begin
      pool_id[i] = (i % 3 == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 2047));
      pool_ext[i] = 1'($urandom);
    end
    pool_id[0] = '1;
    pool_ext[0] = 1'b1;
    pool_id[1] = '1;
    pool_ext[1] = 1'b0;
    pool_id[2] = '0;
    pool_id[5] = pool_id[4];
    pool_ext[5] = !pool_ext[4];

    run_random(120);
    wait_drained();
    program_filter(1'b1, pool_id[4]);
    run_random(100);
    wait_drained();
    idle_on = 1'b0;
    program_filter(1'b1, '1);
    run_random(80);
    wait_drained();
    idle_on = 1'b1;
    program_filter(1'b0, '0);
    run_random(70);
    wait_drained();
    run_random(70);

    wait_drained();
    repeat (150) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
